@@ hw/rtl/target_heading_angle_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Target heading angle unit: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TARGET_HEADING_ANGLE_UNIT_DEFINES_SVH
`define TARGET_HEADING_ANGLE_UNIT_DEFINES_SVH

// condition that must hold at every edge outside reset
`define THAU_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// condition in one cycle implies a condition in the next
`define THAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// state in the cycle after reset is applied
`define THAU_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/thau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target heading angle package
// Widths, angle constants, arctangent table and shared types.
// ----------------------------------------------------------------------------
package thau_pkg;

   localparam int COORD_WIDTH     = 24;
   localparam int CORDIC_STAGES   = 16;
   localparam int ANGLE_FRAC_BITS = 13;

   // coordinate difference and its magnitude
   localparam int DIFF_W    = COORD_WIDTH + 1;
   localparam int POS_W     = $clog2(DIFF_W);
   // magnitudes are normalized so the larger one reaches 2^NORM_BITS
   localparam int NORM_BITS = 40;
   localparam int SHIFT_W   = $clog2(NORM_BITS + 1);
   localparam int CORD_W    = NORM_BITS + 4;
   // angles in Q30 radians, range -pi..pi plus rounding headroom
   localparam int ANG_W     = 33;
   localparam int HEAD_W    = 16;
   localparam int ROUND_SH  = 30 - ANGLE_FRAC_BITS;

   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
   localparam logic signed [ANG_W-1:0] ROUND_HALF  = ANG_W'(1 << (ROUND_SH - 1));
   localparam longint HEAD_LIMIT =
      (2 * 64'sd1686629713 + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;

   // atan(2^-i) in Q30, truncated
   localparam logic [31:0] ATAN_TABLE [24] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
      32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
      32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
      32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   typedef struct packed {
      logic dx_neg;
      logic dz_neg;
      logic dx_zero;
      logic dz_zero;
   } thau_ctl_type;

endpackage

@@ hw/rtl/thau_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target heading angle request channel
// Valid/ready channel carrying one source and one target position.
// ----------------------------------------------------------------------------
interface thau_req_if;
   import thau_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] source_x;
   logic signed [COORD_WIDTH-1:0] source_z;
   logic signed [COORD_WIDTH-1:0] target_x;
   logic signed [COORD_WIDTH-1:0] target_z;

   modport source (output valid, source_x, source_z, target_x, target_z, input ready);
   modport sink   (input valid, source_x, source_z, target_x, target_z, output ready);
endinterface

@@ hw/rtl/thau_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target heading angle response channel
// Valid/ready channel carrying one heading angle.
// ----------------------------------------------------------------------------
interface thau_rsp_if;
   import thau_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [HEAD_W-1:0] heading;

   modport source (output valid, heading, input ready);
   modport sink   (input valid, heading, output ready);
endinterface

@@ hw/rtl/target_heading_angle_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target heading angle unit
// Heading from a source to a target position in the XZ plane via CORDIC.
// ----------------------------------------------------------------------------
// Takes one position pair per cycle while req ready is high and returns its
// heading in signed Q2.13 radians after four front-end stages (difference,
// magnitude, leading-one search, normalizing shift), one stage per CORDIC
// micro-rotation (16), two back-end stages (clamp, quadrant fold) and the
// output register. The micro-rotation chain sets the latency; throughput is
// one item per clock unless held. A two-entry output buffer (output register
// plus skid register) decouples the pipeline from the response side: req ready
// drops only when both entries hold items, and then the whole pipeline holds.
// ----------------------------------------------------------------------------
module target_heading_angle_unit (
   input  logic              clock,
   input  logic              reset,
   thau_req_if.sink          req_chan,
   thau_rsp_if.source        rsp_chan
);
   import thau_pkg::*;

   logic                     advance;
   logic                     norm_valid;
   logic signed [CORD_W-1:0] norm_x, norm_y;
   thau_ctl_type             norm_ctl;
   logic                     cordic_valid;
   logic signed [ANG_W-1:0]  cordic_z;
   thau_ctl_type             cordic_ctl;
   logic                     post_valid;
   logic signed [HEAD_W-1:0] post_heading;

   logic                     out_valid_ff, out_valid_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic signed [HEAD_W-1:0] out_ff, out_in;
   logic signed [HEAD_W-1:0] skid_ff, skid_in;
   logic                     push, pop;

   assign advance        = ~skid_valid_ff;
   assign req_chan.ready = advance;

   thau_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .valid_i  (req_chan.valid),
      .source_x (req_chan.source_x),
      .source_z (req_chan.source_z),
      .target_x (req_chan.target_x),
      .target_z (req_chan.target_z),
      .valid_o  (norm_valid),
      .x_o      (norm_x),
      .y_o      (norm_y),
      .ctl_o    (norm_ctl)
   );

   thau_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (norm_valid),
      .x_i     (norm_x),
      .y_i     (norm_y),
      .ctl_i   (norm_ctl),
      .valid_o (cordic_valid),
      .z_o     (cordic_z),
      .ctl_o   (cordic_ctl)
   );

   thau_post u_post (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_i   (cordic_valid),
      .z_i       (cordic_z),
      .ctl_i     (cordic_ctl),
      .valid_o   (post_valid),
      .heading_o (post_heading)
   );

   assign push = post_valid & advance;
   assign pop  = out_valid_ff & rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      priority if (pop && skid_valid_ff) begin
         // drain the skid entry into the output register
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end else if (pop) begin
         out_valid_in = push;
         out_in       = post_heading;
      end else if (push && !out_valid_ff) begin
         out_valid_in = 1'b1;
         out_in       = post_heading;
      end else if (push) begin
         // output is held: park the item
         skid_valid_in = 1'b1;
         skid_in       = post_heading;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.heading = out_ff;
endmodule

@@ hw/rtl/thau_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target heading angle front end
// Difference, magnitude, leading-one search and normalizing shift, four stages.
// ----------------------------------------------------------------------------
module thau_norm (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   valid_i,
   input  logic signed [thau_pkg::COORD_WIDTH-1:0] source_x,
   input  logic signed [thau_pkg::COORD_WIDTH-1:0] source_z,
   input  logic signed [thau_pkg::COORD_WIDTH-1:0] target_x,
   input  logic signed [thau_pkg::COORD_WIDTH-1:0] target_z,
   output logic                                   valid_o,
   output logic signed [thau_pkg::CORD_W-1:0]      x_o,
   output logic signed [thau_pkg::CORD_W-1:0]      y_o,
   output thau_pkg::thau_ctl_type                 ctl_o
);
   import thau_pkg::*;

   // stage 1: differences
   logic signed [DIFF_W-1:0] dx_in, dz_in, dx_ff, dz_ff;
   logic                     v1_ff;
   // stage 2: magnitudes and quadrant flags
   logic [DIFF_W-1:0]        mx_in, mz_in, mx2_ff, mz2_ff;
   thau_ctl_type             ctl_in, ctl2_ff, ctl3_ff, ctl4_ff;
   logic                     v2_ff;
   // stage 3: shift amount
   logic [DIFF_W-1:0]        any_bits;
   logic [POS_W-1:0]         lead_pos;
   logic [SHIFT_W-1:0]       sh_in, sh3_ff;
   logic [DIFF_W-1:0]        mx3_ff, mz3_ff;
   logic                     v3_ff;
   // stage 4: normalized vector
   logic signed [CORD_W-1:0] x_in, y_in, x_ff, y_ff;
   logic                     v4_ff;

   assign dx_in = {target_x[COORD_WIDTH-1], target_x} - {source_x[COORD_WIDTH-1], source_x};
   assign dz_in = {target_z[COORD_WIDTH-1], target_z} - {source_z[COORD_WIDTH-1], source_z};

   assign mx_in = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
   assign mz_in = dz_ff[DIFF_W-1] ? DIFF_W'(-dz_ff) : DIFF_W'(dz_ff);
   assign ctl_in = '{dx_neg:  dx_ff[DIFF_W-1],
                     dz_neg:  dz_ff[DIFF_W-1],
                     dx_zero: (dx_ff == '0),
                     dz_zero: (dz_ff == '0)};

   // highest set bit of either magnitude is the highest bit of the larger one
   assign any_bits = mx2_ff | mz2_ff;
   always_comb begin
      lead_pos = '0;
      for (int i = 0; i < DIFF_W; i++) begin
         if (any_bits[i]) begin
            lead_pos = POS_W'(i);
         end
      end
   end
   assign sh_in = SHIFT_W'(NORM_BITS) - SHIFT_W'(lead_pos);

   assign x_in = CORD_W'(mx3_ff) << sh3_ff;
   assign y_in = CORD_W'(mz3_ff) << sh3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff   <= dx_in;
         dz_ff   <= dz_in;
         mx2_ff  <= mx_in;
         mz2_ff  <= mz_in;
         ctl2_ff <= ctl_in;
         mx3_ff  <= mx2_ff;
         mz3_ff  <= mz2_ff;
         sh3_ff  <= sh_in;
         ctl3_ff <= ctl2_ff;
         x_ff    <= x_in;
         y_ff    <= y_in;
         ctl4_ff <= ctl3_ff;
      end
   end

   assign valid_o = v4_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign ctl_o   = ctl4_ff;
endmodule

@@ hw/rtl/thau_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target heading angle CORDIC pipeline
// Vectoring mode, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module thau_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              valid_i,
   input  logic signed [thau_pkg::CORD_W-1:0] x_i,
   input  logic signed [thau_pkg::CORD_W-1:0] y_i,
   input  thau_pkg::thau_ctl_type            ctl_i,
   output logic                              valid_o,
   output logic signed [thau_pkg::ANG_W-1:0]  z_o,
   output thau_pkg::thau_ctl_type            ctl_o
);
   import thau_pkg::*;

   localparam int LAST = CORDIC_STAGES - 1;

   // the last stage only needs the angle, so x and y stop one stage early
   logic signed [CORD_W-1:0] x_ff   [LAST];
   logic signed [CORD_W-1:0] y_ff   [LAST];
   logic signed [ANG_W-1:0]  z_ff   [CORDIC_STAGES];
   thau_ctl_type             ctl_ff [CORDIC_STAGES];
   logic                     v_ff   [CORDIC_STAGES];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic signed [CORD_W-1:0] x_prev, y_prev;
      logic signed [ANG_W-1:0]  z_prev, z_in, rot_angle;
      thau_ctl_type             ctl_prev;
      logic                     v_prev;
      logic                     rot_down;

      if (i == 0) begin : g_first
         assign x_prev   = x_i;
         assign y_prev   = y_i;
         assign z_prev   = '0;
         assign ctl_prev = ctl_i;
         assign v_prev   = valid_i;
      end else begin : g_next
         assign x_prev   = x_ff[i-1];
         assign y_prev   = y_ff[i-1];
         assign z_prev   = z_ff[i-1];
         assign ctl_prev = ctl_ff[i-1];
         assign v_prev   = v_ff[i-1];
      end

      // rotate toward the x axis: y still non-negative means rotate down
      assign rot_down  = ~y_prev[CORD_W-1];
      assign rot_angle = ANG_W'(ATAN_TABLE[i]);
      assign z_in      = rot_down ? z_prev + rot_angle : z_prev - rot_angle;

      if (i < LAST) begin : g_rot
         logic signed [CORD_W-1:0] xs, ys, x_in, y_in;

         assign xs   = x_prev >>> i;
         assign ys   = y_prev >>> i;
         assign x_in = rot_down ? x_prev + ys : x_prev - ys;
         assign y_in = rot_down ? y_prev - xs : y_prev + xs;

         always_ff @(posedge clock) begin
            if (advance) begin
               x_ff[i] <= x_in;
               y_ff[i] <= y_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (advance) begin
            v_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            z_ff[i]   <= z_in;
            ctl_ff[i] <= ctl_prev;
         end
      end
   end

   assign valid_o = v_ff[LAST];
   assign z_o     = z_ff[LAST];
   assign ctl_o   = ctl_ff[LAST];
endmodule

@@ hw/rtl/thau_post.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target heading angle back end
// Angle clamp and special cases, quadrant fold, rounding to the output format.
// ----------------------------------------------------------------------------
module thau_post (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              valid_i,
   input  logic signed [thau_pkg::ANG_W-1:0]  z_i,
   input  thau_pkg::thau_ctl_type            ctl_i,
   output logic                              valid_o,
   output logic signed [thau_pkg::HEAD_W-1:0] heading_o
);
   import thau_pkg::*;

   logic signed [ANG_W-1:0] a_in, a_ff;
   thau_ctl_type            ctl_a_ff;
   logic                    va_ff;
   logic signed [ANG_W-1:0] r_in, r_ff;
   logic                    vb_ff;
   logic signed [ANG_W-1:0] biased, scaled;

   // an axis-aligned difference bypasses the rotation result
   always_comb begin
      priority if (ctl_i.dz_zero) begin
         a_in = '0;
      end else if (ctl_i.dx_zero) begin
         a_in = HALF_PI_Q30;
      end else if (z_i < 0) begin
         a_in = '0;
      end else if (z_i > HALF_PI_Q30) begin
         a_in = HALF_PI_Q30;
      end else begin
         a_in = z_i;
      end
   end

   always_comb begin
      unique case ({ctl_a_ff.dx_neg, ctl_a_ff.dz_neg})
         2'b00:   r_in = -HALF_PI_Q30 - a_ff;
         2'b01:   r_in = -HALF_PI_Q30 + a_ff;
         2'b10:   r_in = HALF_PI_Q30 + a_ff;
         default: r_in = HALF_PI_Q30 - a_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= valid_i;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff     <= a_in;
         ctl_a_ff <= ctl_i;
         r_ff     <= r_in;
      end
   end

   // round half up to the output fraction
   assign biased    = r_ff + ROUND_HALF;
   assign scaled    = biased >>> ROUND_SH;
   assign valid_o   = vb_ff;
   assign heading_o = scaled[HEAD_W-1:0];
endmodule

@@ hw/rtl/thau_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target heading angle port checker
// Checks on the top-level ports: output range, back-pressure, reset state.
// ----------------------------------------------------------------------------
`include "target_heading_angle_unit_defines.svh"

module thau_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [thau_pkg::HEAD_W-1:0] rsp_heading
);
   import thau_pkg::*;

   localparam logic signed [HEAD_W-1:0] LIMIT = HEAD_W'(HEAD_LIMIT);

   logic heading_in_range;
   logic req_pending;

   assign heading_in_range = (rsp_heading >= -LIMIT) && (rsp_heading <= LIMIT);
   assign req_pending      = req_valid && !req_ready;

   `THAU_ASSERT_ALWAYS(a_heading_range, !rsp_valid || heading_in_range, "heading outside -pi..pi")
   `THAU_ASSERT_ALWAYS(a_ready_drop, !req_pending || $past(rsp_valid && !rsp_ready), "req stalled without rsp back-pressure")
   `THAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_heading), "stalled rsp item changed")
   `THAU_ASSERT_AFTER_RESET(a_reset_state, !rsp_valid && req_ready, "reset left an item or a stall")
endmodule

bind target_heading_angle_unit thau_checker u_thau_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_heading (rsp_chan.heading)
);
